// ===== src/integer_partition_counter_assert.svh =====
// Assertion macros used by the integer partition counter top level.
`ifndef INTEGER_PARTITION_COUNTER_ASSERT_SVH
`define INTEGER_PARTITION_COUNTER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define IPC_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("integer_partition_counter: check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define IPC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("integer_partition_counter: check failed");

`endif

// ===== src/ipc_pkg.sv =====
// Shared types and constants for the integer partition counter.
package ipc_pkg;

   localparam int MAX_ITEMS_DEFAULT = 32;
   localparam int COUNT_W           = 7;
   localparam int WAYS_W            = 21;

   typedef struct packed {
      logic [COUNT_W-1:0] item_count;
      logic [COUNT_W-1:0] bin_count;
   } req_type;

   typedef struct packed {
      logic [WAYS_W-1:0] ways;
      logic              out_of_range;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_DRAIN,
      ST_RESP
   } ipc_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic issue;
   } ipc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic range_error;
      logic issue_last;
   } ipc_status_type;

endpackage

// ===== src/integer_partition_counter.sv =====
// Top level of the integer partition counter.
//
// An item (item_count m, bin_count n) is taken when start is high while busy is low, and the
// block answers with the number of partitions of m into at most n parts, which is the number
// of ways to put m identical items into n identical bins. The table p(i,j) for 0 <= i <= m
// and 0 <= j <= n is filled row by row, one cell per clock cycle, by a two-stage pipeline
// around a table memory with one read and one write port: one cycle reads p(i-j,j) from an
// earlier row, the next adds it to the cell just computed and writes the sum back. An item
// therefore keeps busy high from the edge that accepts it to the edge that takes its result,
// and the next item can be taken once busy has fallen again, as only one item is in work.
// When m or n exceeds MAX_ITEMS the table is left alone and the result is strobed in the
// cycle straight after acceptance with out_of_range set and ways zero. The result is on
// rsp_item for exactly one cycle, marked by rsp_valid, and the receiver must take it then,
// since it cannot hold the block off. The table needs no clearing after reset, as every cell
// is written before its value is used.
module integer_partition_counter
   import ipc_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

`include "integer_partition_counter_assert.svh"

   ipc_cmd_type    cmd;
   ipc_status_type status;

   // The controller sequences loading, the table sweep and the result strobe.
   ipc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // The datapath holds the counters, the table memory and the adder.
   ipc_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

   // An accepted item keeps the block busy on the following cycle.
   `IPC_ASSERT_NEXT(a_busy_after_accept, clock, reset, start && !busy, busy)
   // Each result is strobed for a single cycle only.
   `IPC_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   // A result is only ever given while an item is still in work.
   `IPC_ASSERT_SAME(a_rsp_while_busy, clock, reset, rsp_valid, busy)
   // An out-of-range item always reports zero ways.
   `IPC_ASSERT_SAME(a_range_zero, clock, reset, rsp_valid && rsp_item.out_of_range,
                    rsp_item.ways == '0)

endmodule

// ===== src/ipc_controller.sv =====
// Controller state machine of the integer partition counter.
module ipc_controller
   import ipc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  ipc_status_type status,
   output ipc_cmd_type    cmd,
   output logic           busy,
   output logic           rsp_valid
);

   ipc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = status.range_error ? ST_RESP : ST_FILL;
            end
         end
         ST_FILL: begin
            if (status.issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_RESP;
         ST_RESP:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_FILL:  cmd.issue = 1'b1;
         ST_DRAIN: cmd.issue = 1'b0;
         ST_RESP:  rsp_valid = 1'b1;
         default:  busy = 1'b1;
      endcase
   end

endmodule

// ===== src/ipc_datapath.sv =====
// Datapath of the integer partition counter: cell counters, table memory and adder.
module ipc_datapath
   import ipc_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
)
(
   input  logic           clock,
   input  logic           reset,
   input  req_type        req_item,
   input  ipc_cmd_type    cmd,
   output ipc_status_type status,
   output rsp_type        rsp_item
);

   localparam int SIDE  = MAX_ITEMS + 1;
   localparam int DEPTH = SIDE * SIDE;
   localparam int CW    = $clog2(SIDE);
   localparam int AW    = $clog2(DEPTH);

   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] row,
                                               input logic [CW-1:0] col);
      cell_addr = AW'(row) * AW'(SIDE) + AW'(col);
   endfunction

   logic [WAYS_W-1:0] table_mem [DEPTH];

   logic [CW-1:0]     m_ff, n_ff;
   logic [CW-1:0]     iss_i_ff, iss_j_ff;
   logic [CW-1:0]     cmp_i_ff, cmp_j_ff;
   logic              cmp_valid_ff;
   logic [WAYS_W-1:0] rd_data_ff;
   logic [WAYS_W-1:0] prev_ff, diag_ff;
   rsp_type           result_ff;

   logic              range_error;
   logic              issue_last;
   logic [AW-1:0]     rd_addr;
   logic [WAYS_W-1:0] cell_value;

   assign range_error = (req_item.item_count > COUNT_W'(MAX_ITEMS)) ||
                        (req_item.bin_count  > COUNT_W'(MAX_ITEMS));
   assign issue_last  = (iss_i_ff == m_ff) && (iss_j_ff == n_ff);

   // The only table read a cell needs is p(i-j, j), from an earlier row.
   assign rd_addr = (iss_j_ff <= iss_i_ff) ? cell_addr(iss_i_ff - iss_j_ff, iss_j_ff) : '0;

   always_comb begin
      priority if (cmp_i_ff == '0) begin
         cell_value = WAYS_W'(1);
      end else if (cmp_j_ff == '0) begin
         cell_value = '0;
      end else if (cmp_j_ff > cmp_i_ff) begin
         cell_value = diag_ff;
      end else begin
         cell_value = WAYS_W'(prev_ff + rd_data_ff);
      end
   end

   // Issue counters walk the table row by row, one cell per cycle while cmd.issue is high.
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_i_ff     <= '0;
         iss_j_ff     <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmd.issue;
         if (cmd.load) begin
            iss_i_ff <= '0;
            iss_j_ff <= '0;
         end else if (cmd.issue) begin
            if (iss_j_ff == n_ff) begin
               iss_j_ff <= '0;
               iss_i_ff <= iss_i_ff + CW'(1);
            end else begin
               iss_j_ff <= iss_j_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         m_ff                   <= CW'(req_item.item_count);
         n_ff                   <= CW'(req_item.bin_count);
         result_ff.ways         <= '0;
         result_ff.out_of_range <= range_error;
      end else if (cmp_valid_ff) begin
         result_ff.ways <= cell_value;
      end
      cmp_i_ff <= iss_i_ff;
      cmp_j_ff <= iss_j_ff;
      if (cmp_valid_ff) begin
         prev_ff <= cell_value;
         if (cmp_j_ff == cmp_i_ff) begin
            diag_ff <= cell_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_valid_ff) begin
         table_mem[cell_addr(cmp_i_ff, cmp_j_ff)] <= cell_value;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   assign status.range_error = range_error;
   assign status.issue_last  = issue_last;
   assign rsp_item           = result_ff;

endmodule

// ===== test/tb_integer_partition_counter.sv =====
// Self-checking testbench for the integer partition counter, directed and random items.
`timescale 1ns / 100ps

module tb_integer_partition_counter;
   import ipc_pkg::*;

   // The block is built with its default table size; the predictor uses the same bound.
   localparam int MAX_ITEMS = MAX_ITEMS_DEFAULT;
   localparam int COUNT_TOP = (1 << COUNT_W) - 1;

   // The watchdog allows eight times the sum of the slowest item's run and the longest
   // sender gap before it gives up.
   localparam int STALL_LIMIT  = 8 * ((MAX_ITEMS + 1) * (MAX_ITEMS + 1) + 3 + 150);
   // Extra wait after the last result while the block settles back to idle.
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 430;
   localparam int REPORT_LIMIT = 10;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   // Expected results, oldest first, one per accepted item.
   rsp_type     pending_counts[$];
   int unsigned mismatches;
   int unsigned items_taken;
   int unsigned range_items;
   int unsigned counts_checked;
   int unsigned idle_cycles;
   // When set, the sender presents items back to back with no gaps between them.
   bit          back_to_back;

   integer_partition_counter #(
      .MAX_ITEMS(MAX_ITEMS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Number of partitions of m into at most n parts, built up in a table of its own row by
   // row. The block's table is always written before its value is used, so earlier items never
   // influence a later answer and a fresh table per item gives the same result.
   function automatic rsp_type count_partitions(input req_type item);
      logic [WAYS_W-1:0] part [0:MAX_ITEMS][0:MAX_ITEMS];
      rsp_type           answer;
      int                m;
      int                n;
      m = item.item_count;
      n = item.bin_count;
      answer = '0;
      if (m > MAX_ITEMS || n > MAX_ITEMS) begin
         answer.out_of_range = 1'b1;
         return answer;
      end
      for (int i = 0; i <= m; i++) begin
         for (int j = 0; j <= n; j++) begin
            if (i == 0)
               part[i][j] = WAYS_W'(1);
            else if (j == 0)
               part[i][j] = '0;
            else if (j > i)
               part[i][j] = part[i][i];
            else
               part[i][j] = part[i][j-1] + part[i-j][j];
         end
      end
      answer.ways = part[m][n];
      return answer;
   endfunction

   // Mostly short gaps between items, now and then a long one, none in back-to-back stretches.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (back_to_back || roll < 40)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 4);
      else
         return $urandom_range(20, 150);
   endfunction

   task automatic note_mismatch(input string what, input int unsigned want, input int unsigned got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
   endtask

   // Presents one item and holds it until the block takes it. If the following gap is zero
   // start simply stays high, so the next item is offered at the very next falling edge.
   task automatic send_item(input int unsigned m, input int unsigned n);
      int gap;
      @(negedge clock);
      start    <= 1'b1;
      req_item <= '{item_count: m[COUNT_W-1:0], bin_count: n[COUNT_W-1:0]};
      do
         @(posedge clock);
      while (busy);
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // With no bins only the empty set of items has a placement.
   task automatic test_no_bins();
      send_item(0, 0);
      send_item(1, 0);
      send_item(5, 0);
      send_item(MAX_ITEMS, 0);
   endtask

   // Corners of the table, including the single-bin and single-item rows and the largest count.
   task automatic test_table_extremes();
      send_item(0, 1);
      send_item(0, MAX_ITEMS);
      send_item(1, 1);
      send_item(1, MAX_ITEMS);
      send_item(MAX_ITEMS, 1);
      send_item(MAX_ITEMS, MAX_ITEMS);
      send_item(MAX_ITEMS - 1, MAX_ITEMS);
      send_item(MAX_ITEMS, MAX_ITEMS - 1);
      send_item(10, 3);
      send_item(3, 10);
   endtask

   // Either count just above the bound or at the top of its field gives the error flag.
   task automatic test_out_of_range();
      send_item(MAX_ITEMS + 1, 5);
      send_item(5, MAX_ITEMS + 1);
      send_item(64, 64);
      send_item(COUNT_TOP, COUNT_TOP);
      send_item(COUNT_TOP, 0);
      send_item(0, COUNT_TOP);
      send_item(100, 1);
      // A valid item straight after an error checks that the error leaves nothing behind.
      send_item(7, 7);
   endtask

   // Mostly in-range counts, with a share across the whole field so that the upper bits are
   // exercised as well. Stretches alternate between random gaps and back-to-back items.
   task automatic test_random_counts();
      int unsigned m;
      int unsigned n;
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         back_to_back = ((k / 40) % 2) == 1;
         if ($urandom_range(0, 99) < 80) begin
            m = $urandom_range(0, MAX_ITEMS);
            n = $urandom_range(0, MAX_ITEMS);
         end else begin
            m = $urandom_range(0, COUNT_TOP);
            n = $urandom_range(0, COUNT_TOP);
         end
         send_item(m, n);
      end
      back_to_back = 1'b0;
   endtask

   // Records each accepted item with its expected answer and checks every result against
   // the oldest answer still waiting.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_counts.size() == 0) begin
               note_mismatch("result with no item waiting", 0, rsp_item.ways);
            end else begin
               want = pending_counts.pop_front();
               counts_checked++;
               if (rsp_item.ways !== want.ways)
                  note_mismatch("ways", want.ways, rsp_item.ways);
               if (rsp_item.out_of_range !== want.out_of_range)
                  note_mismatch("out_of_range", want.out_of_range, rsp_item.out_of_range);
            end
         end
         if (start && !busy) begin
            want = count_partitions(req_item);
            pending_counts.push_back(want);
            items_taken++;
            if (want.out_of_range)
               range_items++;
         end
      end
   end

   // Ends the run if neither side moves anything for far longer than any correct run needs.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      mismatches     = 0;
      items_taken    = 0;
      range_items    = 0;
      counts_checked = 0;
      idle_cycles    = 0;
      back_to_back   = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_item       = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_no_bins();
      test_table_extremes();
      test_out_of_range();
      test_random_counts();

      // Withdraw start so that the last item is not offered a second time.
      @(negedge clock);
      start <= 1'b0;
      while (pending_counts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d items, %0d of them with a count beyond the table,",
               items_taken, range_items);
      $display("and checked %0d results with %0d mismatches.", counts_checked, mismatches);
      if (mismatches == 0 && pending_counts.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
